// ===== hdl/sha512_pkg.sv =====
package sha512_pkg;

  localparam int unsigned WordW = 64;

  localparam logic [WordW-1:0] PadWord = 64'h8000_0000_0000_0000;

  // Control from the sequencer to the round datapath.
  typedef struct packed {
    logic       var_wr;     // load one working variable from chain read data
    logic [2:0] var_idx;    // working variable selected for load or readout
    logic       round;      // perform one compression round
    logic [6:0] round_idx;  // round number, selects the round constant
    logic       wt_load;    // update the current schedule word
    logic       wt_mem;     // take the schedule word from the block buffer
  } core_ctrl_t;

  function automatic logic [WordW-1:0] init_hash(input logic [2:0] idx);
    logic [WordW-1:0] v;
    unique case (idx)
      3'd0: v = 64'h6a09e667f3bcc908;
      3'd1: v = 64'hbb67ae8584caa73b;
      3'd2: v = 64'h3c6ef372fe94f82b;
      3'd3: v = 64'ha54ff53a5f1d36f1;
      3'd4: v = 64'h510e527fade682d1;
      3'd5: v = 64'h9b05688c2b3e6c1f;
      3'd6: v = 64'h1f83d9abfb41bd6b;
      default: v = 64'h5be0cd19137e2179;
    endcase
    return v;
  endfunction

  function automatic logic [WordW-1:0] round_const(input logic [6:0] idx);
    logic [WordW-1:0] k;
    unique case (idx)
      7'd0:  k = 64'h428a2f98d728ae22;  7'd1:  k = 64'h7137449123ef65cd;
      7'd2:  k = 64'hb5c0fbcfec4d3b2f;  7'd3:  k = 64'he9b5dba58189dbbc;
      7'd4:  k = 64'h3956c25bf348b538;  7'd5:  k = 64'h59f111f1b605d019;
      7'd6:  k = 64'h923f82a4af194f9b;  7'd7:  k = 64'hab1c5ed5da6d8118;
      7'd8:  k = 64'hd807aa98a3030242;  7'd9:  k = 64'h12835b0145706fbe;
      7'd10: k = 64'h243185be4ee4b28c;  7'd11: k = 64'h550c7dc3d5ffb4e2;
      7'd12: k = 64'h72be5d74f27b896f;  7'd13: k = 64'h80deb1fe3b1696b1;
      7'd14: k = 64'h9bdc06a725c71235;  7'd15: k = 64'hc19bf174cf692694;
      7'd16: k = 64'he49b69c19ef14ad2;  7'd17: k = 64'hefbe4786384f25e3;
      7'd18: k = 64'h0fc19dc68b8cd5b5;  7'd19: k = 64'h240ca1cc77ac9c65;
      7'd20: k = 64'h2de92c6f592b0275;  7'd21: k = 64'h4a7484aa6ea6e483;
      7'd22: k = 64'h5cb0a9dcbd41fbd4;  7'd23: k = 64'h76f988da831153b5;
      7'd24: k = 64'h983e5152ee66dfab;  7'd25: k = 64'ha831c66d2db43210;
      7'd26: k = 64'hb00327c898fb213f;  7'd27: k = 64'hbf597fc7beef0ee4;
      7'd28: k = 64'hc6e00bf33da88fc2;  7'd29: k = 64'hd5a79147930aa725;
      7'd30: k = 64'h06ca6351e003826f;  7'd31: k = 64'h142929670a0e6e70;
      7'd32: k = 64'h27b70a8546d22ffc;  7'd33: k = 64'h2e1b21385c26c926;
      7'd34: k = 64'h4d2c6dfc5ac42aed;  7'd35: k = 64'h53380d139d95b3df;
      7'd36: k = 64'h650a73548baf63de;  7'd37: k = 64'h766a0abb3c77b2a8;
      7'd38: k = 64'h81c2c92e47edaee6;  7'd39: k = 64'h92722c851482353b;
      7'd40: k = 64'ha2bfe8a14cf10364;  7'd41: k = 64'ha81a664bbc423001;
      7'd42: k = 64'hc24b8b70d0f89791;  7'd43: k = 64'hc76c51a30654be30;
      7'd44: k = 64'hd192e819d6ef5218;  7'd45: k = 64'hd69906245565a910;
      7'd46: k = 64'hf40e35855771202a;  7'd47: k = 64'h106aa07032bbd1b8;
      7'd48: k = 64'h19a4c116b8d2d0c8;  7'd49: k = 64'h1e376c085141ab53;
      7'd50: k = 64'h2748774cdf8eeb99;  7'd51: k = 64'h34b0bcb5e19b48a8;
      7'd52: k = 64'h391c0cb3c5c95a63;  7'd53: k = 64'h4ed8aa4ae3418acb;
      7'd54: k = 64'h5b9cca4f7763e373;  7'd55: k = 64'h682e6ff3d6b2b8a3;
      7'd56: k = 64'h748f82ee5defb2fc;  7'd57: k = 64'h78a5636f43172f60;
      7'd58: k = 64'h84c87814a1f0ab72;  7'd59: k = 64'h8cc702081a6439ec;
      7'd60: k = 64'h90befffa23631e28;  7'd61: k = 64'ha4506cebde82bde9;
      7'd62: k = 64'hbef9a3f7b2c67915;  7'd63: k = 64'hc67178f2e372532b;
      7'd64: k = 64'hca273eceea26619c;  7'd65: k = 64'hd186b8c721c0c207;
      7'd66: k = 64'heada7dd6cde0eb1e;  7'd67: k = 64'hf57d4f7fee6ed178;
      7'd68: k = 64'h06f067aa72176fba;  7'd69: k = 64'h0a637dc5a2c898a6;
      7'd70: k = 64'h113f9804bef90dae;  7'd71: k = 64'h1b710b35131c471b;
      7'd72: k = 64'h28db77f523047d84;  7'd73: k = 64'h32caab7b40c72493;
      7'd74: k = 64'h3c9ebe0a15c9bebc;  7'd75: k = 64'h431d67c49c100d4c;
      7'd76: k = 64'h4cc5d4becb3e42b6;  7'd77: k = 64'h597f299cfc657e2a;
      7'd78: k = 64'h5fcb6fab3ad6faec;  7'd79: k = 64'h6c44198c4a475817;
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

// ===== hdl/sha512_hash_engine_unit.sv =====
// SHA-512 hash engine. Message words enter on the slave stream as big-endian 64-bit
// items with a count of valid bytes; the item flagged by tlast ends the message and
// causes eight digest items on the master stream, H0 first, the eighth flagged by
// tlast. Words are written into a 16-entry block buffer memory; the chaining value
// lives in an 8-entry memory that reads back as the standard initial value until
// written, and is returned to that value after each digest. A full block of 16 words is
// followed by a compression: loading the working variables from the chain memory, 80
// rounds at one round per cycle, and adding back into the chain memory through its
// single read and write port; the input is not ready during compression. The final
// word is followed by pushing the pad and length words and possibly a second
// compression. Each digest item is read from the chain memory once the previous read has
// landed, and the digest leaves through a single
// output register, which may still hold the last digest item while the next message
// is being accepted. The block buffer is only written while the engine gathers
// words and only read while it compresses, so the two never touch the same entry.
module sha512_hash_engine_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Message items.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,   // [63:0] data_word, [67:64] valid_bytes, rest zero
  input  logic        s_axis_tlast_i,   // last_word
  // Digest items.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o,   // [63:0] digest_word, [66:64] digest_index, rest zero
  output logic        m_axis_tlast_o    // digest_last
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_PUSH, ST_LOAD, ST_ROUND, ST_FINAL, ST_OUT
  } state_e;

  // Which padding word comes next.
  typedef enum logic [1:0] {
    PD_NONE, PD_WORD, PD_ZERO, PD_LEN
  } pad_e;

  state_e      state_q, state_d;
  pad_e        pad_q, pad_d;
  logic [3:0]  pos_q, pos_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        final_q, final_d;
  logic [63:0] bitlen_q, bitlen_d;
  logic [3:0]  out_cnt_q, out_cnt_d;
  logic        pend_q, pend_d;
  logic        m_valid_q, m_valid_d;
  logic [63:0] m_word_q, m_word_d;
  logic [2:0]  m_idx_q, m_idx_d;

  logic        accept, rd_issue;
  logic [63:0] in_word;
  logic [3:0]  in_nbytes, nv;
  logic [63:0] keep, pad_bit, last_word;

  logic        blk_we;
  logic [3:0]  blk_raddr;
  logic [63:0] blk_wdata, blk_rdata;

  logic        chain_we, chain_clr;
  logic [2:0]  chain_raddr, chain_waddr;
  logic [63:0] chain_rdata, chain_wdata, var_sel;

  sha512_pkg::core_ctrl_t core_ctrl;

  assign in_word   = s_axis_tdata_i[63:0];
  assign in_nbytes = s_axis_tdata_i[67:64];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // The last word keeps its valid bytes, clears the rest and carries the pad byte
  // right after them; with eight valid bytes the pad goes into a word of its own.
  always_comb begin
    nv        = (in_nbytes > 4'd8) ? 4'd8 : in_nbytes;
    keep      = ~({64{1'b1}} >> {nv[2:0], 3'b000});
    pad_bit   = sha512_pkg::PadWord >> {nv[2:0], 3'b000};
    last_word = (nv == 4'd8) ? in_word : ((in_word & keep) | pad_bit);
  end

  always_comb begin
    blk_we    = 1'b0;
    blk_wdata = in_word;
    if (accept) begin
      blk_we    = 1'b1;
      blk_wdata = s_axis_tlast_i ? last_word : in_word;
    end else if (state_q == ST_PUSH) begin
      blk_we = 1'b1;
      case (pad_q)
        PD_WORD: blk_wdata = sha512_pkg::PadWord;
        PD_LEN:  blk_wdata = bitlen_q;
        default: blk_wdata = '0;
      endcase
    end
  end

  // Schedule words are fetched from the block buffer ahead of the rounds that use them;
  // while loading, word zero is fetched until the last load step, which fetches word one.
  assign blk_raddr = (state_q == ST_LOAD) ? {3'b000, cnt_q == 7'd8} : cnt_q[3:0] + 4'd2;

  assign rd_issue = (state_q == ST_OUT) && (out_cnt_q != 4'd8) && !pend_q &&
                    (!m_valid_q || m_axis_tready_i);

  assign chain_raddr = (state_q == ST_OUT) ? out_cnt_q[2:0] : cnt_q[2:0];
  assign chain_we    = (state_q == ST_FINAL) && (cnt_q != 7'd0);
  assign chain_waddr = cnt_q[2:0] - 3'd1;
  assign chain_wdata = chain_rdata + var_sel;
  assign chain_clr   = (state_q == ST_OUT) && pend_q && (out_cnt_q == 4'd8);

  always_comb begin
    core_ctrl.var_wr    = (state_q == ST_LOAD) && (cnt_q != 7'd0);
    core_ctrl.var_idx   = cnt_q[2:0] - 3'd1;
    core_ctrl.round     = (state_q == ST_ROUND);
    core_ctrl.round_idx = cnt_q;
    core_ctrl.wt_load   = ((state_q == ST_LOAD) && (cnt_q == 7'd8)) || (state_q == ST_ROUND);
    core_ctrl.wt_mem    = (state_q == ST_LOAD) || (cnt_q < 7'd15);
  end

  always_comb begin
    state_d   = state_q;
    pad_d     = pad_q;
    pos_d     = pos_q;
    cnt_d     = cnt_q;
    final_d   = final_q;
    bitlen_d  = bitlen_q;
    out_cnt_d = out_cnt_q;
    pend_d    = 1'b0;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    m_word_d  = m_word_q;
    m_idx_d   = m_idx_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          pos_d = pos_q + 4'd1;
          if (s_axis_tlast_i) begin
            bitlen_d = bitlen_q + {57'd0, nv, 3'b000};
            pad_d    = (nv == 4'd8) ? PD_WORD : PD_ZERO;
          end else begin
            bitlen_d = bitlen_q + 64'd64;
          end
          if (pos_q == 4'd15) begin
            state_d = ST_LOAD;
            cnt_d   = '0;
          end else if (s_axis_tlast_i) begin
            state_d = ST_PUSH;
          end
        end
      end
      ST_PUSH: begin
        pos_d = pos_q + 4'd1;
        case (pad_q)
          PD_WORD: pad_d = PD_ZERO;
          PD_ZERO: pad_d = (pos_q == 4'd14) ? PD_LEN : PD_ZERO;
          default: begin
            pad_d   = PD_NONE;
            final_d = 1'b1;
          end
        endcase
        if (pos_q == 4'd15) begin
          state_d = ST_LOAD;
          cnt_d   = '0;
        end
      end
      ST_LOAD: begin
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd8) begin
          state_d = ST_ROUND;
          cnt_d   = '0;
        end
      end
      ST_ROUND: begin
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd79) begin
          state_d = ST_FINAL;
          cnt_d   = '0;
        end
      end
      ST_FINAL: begin
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd8) begin
          cnt_d = '0;
          if (final_q) begin
            state_d   = ST_OUT;
            out_cnt_d = '0;
          end else if (pad_q != PD_NONE) begin
            state_d = ST_PUSH;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_OUT: begin
        if (rd_issue) begin
          pend_d    = 1'b1;
          out_cnt_d = out_cnt_q + 4'd1;
        end
        if (pend_q) begin
          m_valid_d = 1'b1;
          m_word_d  = chain_rdata;
          m_idx_d   = out_cnt_q[2:0] - 3'd1;
          if (out_cnt_q == 4'd8) begin
            state_d  = ST_IDLE;
            final_d  = 1'b0;
            bitlen_d = '0;
            pos_d    = '0;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pad_q     <= PD_NONE;
      pos_q     <= '0;
      cnt_q     <= '0;
      final_q   <= 1'b0;
      bitlen_q  <= '0;
      out_cnt_q <= '0;
      pend_q    <= 1'b0;
      m_valid_q <= 1'b0;
      m_word_q  <= '0;
      m_idx_q   <= '0;
    end else begin
      state_q   <= state_d;
      pad_q     <= pad_d;
      pos_q     <= pos_d;
      cnt_q     <= cnt_d;
      final_q   <= final_d;
      bitlen_q  <= bitlen_d;
      out_cnt_q <= out_cnt_d;
      pend_q    <= pend_d;
      m_valid_q <= m_valid_d;
      m_word_q  <= m_word_d;
      m_idx_q   <= m_idx_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {5'd0, m_idx_q, m_word_q};
  assign m_axis_tlast_o  = (m_idx_q == 3'd7);

  sha512_block_mem u_block_mem (
    .clk_i   (clk_i),
    .we_i    (blk_we),
    .waddr_i (pos_q),
    .wdata_i (blk_wdata),
    .raddr_i (blk_raddr),
    .rdata_o (blk_rdata)
  );

  sha512_chain_mem u_chain_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (chain_clr),
    .we_i    (chain_we),
    .waddr_i (chain_waddr),
    .wdata_i (chain_wdata),
    .raddr_i (chain_raddr),
    .rdata_o (chain_rdata)
  );

  sha512_core u_core (
    .clk_i         (clk_i),
    .ctrl_i        (core_ctrl),
    .blk_rdata_i   (blk_rdata),
    .chain_rdata_i (chain_rdata),
    .var_o         (var_sel)
  );

  // A digest read is only issued when the output register is free by the time its
  // data arrives.
  a_out_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !m_valid_q)
    else $error("digest read landed on an occupied output register");

  // A last word always starts padding or a compression.
  a_last_pads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tlast_i) |=> (state_q == ST_PUSH || state_q == ST_LOAD))
    else $error("last word did not start padding");

  // The block buffer is never written while a compression reads it.
  a_blk_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blk_we |-> (state_q == ST_IDLE || state_q == ST_PUSH))
    else $error("block buffer written during compression");

  // The round counter stays within the eighty rounds.
  a_round_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND) |-> (cnt_q < 7'd80))
    else $error("round counter out of range");

endmodule

// ===== hdl/sha512_block_mem.sv =====
module sha512_block_mem (
  input  logic        clk_i,
  input  logic        we_i,
  input  logic [3:0]  waddr_i,
  input  logic [63:0] wdata_i,
  input  logic [3:0]  raddr_i,
  output logic [63:0] rdata_o
);

  logic [63:0] mem_q [16];
  logic [63:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/sha512_chain_mem.sv =====
module sha512_chain_mem (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        clr_i,
  input  logic        we_i,
  input  logic [2:0]  waddr_i,
  input  logic [63:0] wdata_i,
  input  logic [2:0]  raddr_i,
  output logic [63:0] rdata_o
);

  logic [63:0] mem_q [8];
  logic [7:0]  valid_q;
  logic [63:0] rdata_q;

  // An entry that is not valid reads as the initial hash value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (clr_i) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= valid_q[raddr_i] ? mem_q[raddr_i] : sha512_pkg::init_hash(raddr_i);
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/sha512_core.sv =====
module sha512_core (
  input  logic                   clk_i,
  input  sha512_pkg::core_ctrl_t ctrl_i,
  input  logic [63:0]            blk_rdata_i,
  input  logic [63:0]            chain_rdata_i,
  output logic [63:0]            var_o
);

  function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction

  logic [63:0] var_q [8];
  logic [63:0] win_q [16];
  logic [63:0] wt_q;

  logic [63:0] big0, big1, ch, maj, t1, t2, sig0, sig1, w_next, wt_d;

  always_comb begin
    big1   = rotr(var_q[4], 14) ^ rotr(var_q[4], 18) ^ rotr(var_q[4], 41);
    ch     = (var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6]);
    big0   = rotr(var_q[0], 28) ^ rotr(var_q[0], 34) ^ rotr(var_q[0], 39);
    maj    = (var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]);
    t1     = var_q[7] + big1 + ch + sha512_pkg::round_const(ctrl_i.round_idx) + wt_q;
    t2     = big0 + maj;
    // The window holds W[t-16..t-1] during round t, so W[t+1] is formed during round t.
    sig0   = rotr(win_q[2], 1) ^ rotr(win_q[2], 8) ^ (win_q[2] >> 7);
    sig1   = rotr(win_q[15], 19) ^ rotr(win_q[15], 61) ^ (win_q[15] >> 6);
    w_next = sig1 + win_q[10] + sig0 + win_q[1];
    wt_d   = ctrl_i.wt_mem ? blk_rdata_i : w_next;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.var_wr) begin
      var_q[ctrl_i.var_idx] <= chain_rdata_i;
    end
    if (ctrl_i.round) begin
      var_q[7] <= var_q[6];
      var_q[6] <= var_q[5];
      var_q[5] <= var_q[4];
      var_q[4] <= var_q[3] + t1;
      var_q[3] <= var_q[2];
      var_q[2] <= var_q[1];
      var_q[1] <= var_q[0];
      var_q[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[15] <= wt_q;
    end
    if (ctrl_i.wt_load) begin
      wt_q <= wt_d;
    end
  end

  assign var_o = var_q[ctrl_i.var_idx];

endmodule
